// File: design/pdfe_pkg.sv
package pdfe_pkg;

	// command opcodes
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_FADE   = 3'd1;
	localparam logic [2:0] OP_LEVEL  = 3'd2;
	localparam logic [2:0] OP_DIRECT = 3'd3;
	localparam logic [2:0] OP_LOAD   = 3'd4;

	// channel modes
	localparam logic [2:0] MODE_OFF  = 3'd0;
	localparam logic [2:0] MODE_ON   = 3'd1;
	localparam logic [2:0] MODE_UP   = 3'd2;
	localparam logic [2:0] MODE_DOWN = 3'd3;
	localparam logic [2:0] MODE_DONE = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_PULSE_MIN = 2'd0;
	localparam logic [1:0] CFG_PULSE_MAX = 2'd1;
	localparam logic [1:0] CFG_MAINS_HZ  = 2'd2;

	// level codes of set level
	localparam logic [7:0] LEVEL_OFF    = 8'd0;
	localparam logic [7:0] LEVEL_RECALL = 8'd255;

	// fixed arithmetic constants
	localparam int MS_PER_SEC = 1000;
	localparam int ROUND_HALF = 128;

	// shared divider widths
	localparam int DIV_NUM_W = 48;
	localparam int DIV_DEN_W = 32;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LT_MUL,
		ST_LT_DIV,
		ST_LT_WAIT,
		ST_LT_WR,
		ST_SF_MUL,
		ST_SF_DIV,
		ST_SF_WAIT,
		ST_SF_SET,
		ST_SL_RD,
		ST_SL_GET,
		ST_CH_CHECK,
		ST_ZS_RD,
		ST_ZS_GET,
		ST_FD_MUL,
		ST_FD_DIV,
		ST_FD_WAIT,
		ST_FD_LV,
		ST_FD_RD1,
		ST_FD_GET1,
		ST_FD_RD2,
		ST_FD_GET2,
		ST_FD_MUL2,
		ST_FD_CORR,
		ST_FD_FIN,
		ST_EMIT
	} state_t;

	// divider handshake
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

endpackage

// File: design/pdfe_ram.sv
module pdfe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/pdfe_div.sv
module pdfe_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pdfe_pkg::div_req_t              req,
	input  logic [pdfe_pkg::DIV_NUM_W-1:0]  dividend,
	input  logic [pdfe_pkg::DIV_DEN_W-1:0]  divisor,
	output pdfe_pkg::div_rsp_t              rsp,
	output logic [pdfe_pkg::DIV_NUM_W-1:0]  quotient
);

	localparam int NW = pdfe_pkg::DIV_NUM_W;
	localparam int DW = pdfe_pkg::DIV_DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_sh;
	logic          fits;

	// restoring step: one quotient bit a cycle
	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign rsp.busy = cnt_q != '0;
	assign rsp.done = done_q;
	assign quotient = quo_q;

endmodule

// File: design/phase_dimmer_fade_engine_unit.sv
// channel   direction  handshake              payload
// s_axis    in         s_tvalid / s_tready    s_tuser opcode, s_tdata command fields
// m_axis    out        m_tvalid / m_tready    m_tdata channel state, m_tlast last of item
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// one item at a time; the shared divider gives one quotient bit a cycle
// load table and set fade use the divider; set level and set direct do not
// a tick emits one result per channel; only fading channels with a nonzero span use the divider
// reset clears all channel state; curve entries hold garbage until loaded
// results sit in an output register, so a stall on m_axis holds the sequencer only
// when another result is due while the register still holds one
module phase_dimmer_fade_engine_unit #(
	parameter int CURVE_SIZE  = 254,
	parameter int CURVE_SCALE = 16384,
	parameter int CHANNELS    = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,  // opcode
	// channel, duration_ms, level, direct_value, table_index, table_increment, pad
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_channel, brightness, phase_value, output_enable, mode, pad
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int NW  = pdfe_pkg::DIV_NUM_W;
	localparam int DW  = pdfe_pkg::DIV_DEN_W;
	localparam logic [7:0] CS = 8'(CURVE_SIZE);

	pdfe_pkg::state_t state_q, state_d;

	// configuration
	logic [15:0] pulse_min_q, pulse_max_q;
	logic [6:0]  mains_hz_q;

	// latched command
	logic [2:0]  op_q;
	logic        chan_in_q;
	logic [15:0] dur_q;
	logic [7:0]  lvl_q;
	logic [15:0] direct_q;
	logic [7:0]  idx_q;
	logic [15:0] inc_q;

	// global and per-channel state
	logic [31:0] curve_sum_q, cycle_q;
	logic [2:0]  chan_mode_q        [CHANNELS];
	logic [7:0]  chan_level_q       [CHANNELS];
	logic [7:0]  chan_start_level_q [CHANNELS];
	logic [7:0]  chan_end_level_q   [CHANNELS];
	logic [7:0]  chan_level_span_q  [CHANNELS];
	logic [31:0] chan_start_cycle_q [CHANNELS];
	logic [31:0] chan_end_cycle_q   [CHANNELS];
	logic [31:0] chan_cycle_span_q  [CHANNELS];
	logic [15:0] chan_phase_q       [CHANNELS];
	logic        chan_enable_q      [CHANNELS];

	// sequencer scratch
	logic [CHW-1:0] ch_q;
	logic [31:0]    now_q;
	logic           up_q;
	logic [7:0]     lv_q, frac_q;
	logic [15:0]    ph_q, dd_q;
	logic [47:0]    mul_q;

	// output register
	logic        m_tvalid_q, m_tlast_q;
	logic [31:0] m_tdata_q;

	// shared units
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic [NW-1:0] div_num, div_quo;
	logic [DW-1:0] div_den;
	pdfe_pkg::div_req_t div_req;
	pdfe_pkg::div_rsp_t div_rsp;
	logic        ram_we;
	logic [7:0]  ram_waddr, ram_raddr;
	logic [15:0] ram_wdata, ram_rdata;

	// combinational helpers
	logic        s_acc, out_free, out_load, is_last, chan_ok;
	logic [7:0]  lvl_sat;
	logic [31:0] now_c, s_c, e_c;
	logic [9:0]  lv_w;
	logic [7:0]  lv_c;
	logic [15:0] d_c;
	logic [24:0] corr_w;
	logic [15:0] corr_c;

	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign is_last  = (op_q != pdfe_pkg::OP_TICK) || (ch_q == CHW'(CHANNELS - 1));
	assign chan_ok  = 32'(chan_in_q) < CHANNELS;
	assign lvl_sat  = (lvl_q > CS) ? CS : lvl_q;
	assign d_c      = pulse_max_q - pulse_min_q;

	// fade window clamp of the current cycle
	assign s_c = chan_start_cycle_q[ch_q];
	assign e_c = chan_end_cycle_q[ch_q];
	always_comb begin
		now_c = cycle_q;
		if (s_c < e_c) begin
			if (cycle_q < s_c || cycle_q > e_c) now_c = e_c;
		end else begin
			if (cycle_q < s_c && cycle_q > e_c) now_c = e_c;
		end
	end

	// fade level from quotient, clamped to the curve
	always_comb begin
		if (up_q) begin
			lv_w = {2'b00, chan_start_level_q[ch_q]} + {2'b00, div_quo[15:8]};
		end else begin
			lv_w = {2'b00, chan_start_level_q[ch_q]} - {2'b00, div_quo[15:8]};
		end
		if (lv_w[9]) begin
			lv_c = 8'd0;
		end else if (lv_w > {2'b00, CS}) begin
			lv_c = CS;
		end else begin
			lv_c = lv_w[7:0];
		end
	end

	// rounded interpolation correction
	assign corr_w = mul_q[24:0] + 25'(pdfe_pkg::ROUND_HALF);
	assign corr_c = corr_w[23:8];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pdfe_pkg::ST_IDLE: begin
				if (s_acc) state_d = pdfe_pkg::ST_DECODE;
			end
			pdfe_pkg::ST_DECODE: begin
				case (op_q)
					pdfe_pkg::OP_TICK: state_d = pdfe_pkg::ST_CH_CHECK;
					pdfe_pkg::OP_LOAD: state_d = pdfe_pkg::ST_LT_MUL;
					pdfe_pkg::OP_FADE: begin
						state_d = chan_ok ? pdfe_pkg::ST_SF_MUL : pdfe_pkg::ST_IDLE;
					end
					pdfe_pkg::OP_LEVEL: begin
						if (!chan_ok) begin
							state_d = pdfe_pkg::ST_IDLE;
						end else if (lvl_q == pdfe_pkg::LEVEL_OFF
								|| lvl_q == pdfe_pkg::LEVEL_RECALL) begin
							state_d = pdfe_pkg::ST_EMIT;
						end else begin
							state_d = pdfe_pkg::ST_SL_RD;
						end
					end
					pdfe_pkg::OP_DIRECT: begin
						state_d = chan_ok ? pdfe_pkg::ST_EMIT : pdfe_pkg::ST_IDLE;
					end
					default: state_d = pdfe_pkg::ST_IDLE;
				endcase
			end
			pdfe_pkg::ST_LT_MUL:  state_d = pdfe_pkg::ST_LT_DIV;
			pdfe_pkg::ST_LT_DIV:  state_d = pdfe_pkg::ST_LT_WAIT;
			pdfe_pkg::ST_LT_WAIT: if (div_rsp.done) state_d = pdfe_pkg::ST_LT_WR;
			pdfe_pkg::ST_LT_WR:   state_d = pdfe_pkg::ST_IDLE;
			pdfe_pkg::ST_SF_MUL:  state_d = pdfe_pkg::ST_SF_DIV;
			pdfe_pkg::ST_SF_DIV:  state_d = pdfe_pkg::ST_SF_WAIT;
			pdfe_pkg::ST_SF_WAIT: if (div_rsp.done) state_d = pdfe_pkg::ST_SF_SET;
			pdfe_pkg::ST_SF_SET:  state_d = pdfe_pkg::ST_EMIT;
			pdfe_pkg::ST_SL_RD:   state_d = pdfe_pkg::ST_SL_GET;
			pdfe_pkg::ST_SL_GET:  state_d = pdfe_pkg::ST_EMIT;
			pdfe_pkg::ST_CH_CHECK: begin
				if (chan_mode_q[ch_q] != pdfe_pkg::MODE_UP
						&& chan_mode_q[ch_q] != pdfe_pkg::MODE_DOWN) begin
					state_d = pdfe_pkg::ST_EMIT;
				end else if (chan_cycle_span_q[ch_q] == 32'd0) begin
					state_d = pdfe_pkg::ST_ZS_RD;
				end else begin
					state_d = pdfe_pkg::ST_FD_MUL;
				end
			end
			pdfe_pkg::ST_ZS_RD:   state_d = pdfe_pkg::ST_ZS_GET;
			pdfe_pkg::ST_ZS_GET:  state_d = pdfe_pkg::ST_EMIT;
			pdfe_pkg::ST_FD_MUL:  state_d = pdfe_pkg::ST_FD_DIV;
			pdfe_pkg::ST_FD_DIV:  state_d = pdfe_pkg::ST_FD_WAIT;
			pdfe_pkg::ST_FD_WAIT: if (div_rsp.done) state_d = pdfe_pkg::ST_FD_LV;
			pdfe_pkg::ST_FD_LV: begin
				state_d = (lv_c == 8'd0) ? pdfe_pkg::ST_FD_FIN : pdfe_pkg::ST_FD_RD1;
			end
			pdfe_pkg::ST_FD_RD1:  state_d = pdfe_pkg::ST_FD_GET1;
			pdfe_pkg::ST_FD_GET1: begin
				if ((up_q && lv_q != CS) || (!up_q && lv_q != 8'd1)) begin
					state_d = pdfe_pkg::ST_FD_RD2;
				end else begin
					state_d = pdfe_pkg::ST_FD_FIN;
				end
			end
			pdfe_pkg::ST_FD_RD2:  state_d = pdfe_pkg::ST_FD_GET2;
			pdfe_pkg::ST_FD_GET2: state_d = pdfe_pkg::ST_FD_MUL2;
			pdfe_pkg::ST_FD_MUL2: state_d = pdfe_pkg::ST_FD_CORR;
			pdfe_pkg::ST_FD_CORR: state_d = pdfe_pkg::ST_FD_FIN;
			pdfe_pkg::ST_FD_FIN:  state_d = pdfe_pkg::ST_EMIT;
			pdfe_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = is_last ? pdfe_pkg::ST_IDLE : pdfe_pkg::ST_CH_CHECK;
				end
			end
			default: state_d = pdfe_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: unit operands, memory ports, handshakes
	always_comb begin
		s_tready    = 1'b0;
		mul_a       = '0;
		mul_b       = '0;
		div_req     = '0;
		div_num     = '0;
		div_den     = '0;
		ram_we      = 1'b0;
		ram_waddr   = idx_q;
		ram_wdata   = pulse_max_q - div_quo[15:0];
		ram_raddr   = lv_q - 8'd1;
		out_load    = 1'b0;
		case (state_q)
			pdfe_pkg::ST_IDLE: s_tready = 1'b1;
			pdfe_pkg::ST_LT_MUL: begin
				mul_a = curve_sum_q;
				mul_b = d_c;
			end
			pdfe_pkg::ST_LT_DIV: begin
				div_req.start = 1'b1;
				div_num       = mul_q + NW'(CURVE_SCALE / 2);
				div_den       = DW'(CURVE_SCALE);
			end
			pdfe_pkg::ST_LT_WR: ram_we = 1'b1;
			pdfe_pkg::ST_SF_MUL: begin
				mul_a = {16'd0, dur_q};
				mul_b = {8'd0, mains_hz_q, 1'b0};
			end
			pdfe_pkg::ST_SF_DIV: begin
				div_req.start = 1'b1;
				div_num       = mul_q;
				div_den       = DW'(pdfe_pkg::MS_PER_SEC);
			end
			pdfe_pkg::ST_SL_RD: ram_raddr = lvl_sat - 8'd1;
			pdfe_pkg::ST_FD_MUL: begin
				mul_a = now_q - s_c;
				mul_b = {8'd0, chan_level_span_q[ch_q]};
			end
			pdfe_pkg::ST_FD_DIV: begin
				div_req.start = 1'b1;
				div_num       = {mul_q[39:0], 8'd0};
				div_den       = chan_cycle_span_q[ch_q];
			end
			pdfe_pkg::ST_FD_RD2: ram_raddr = up_q ? lv_q : lv_q - 8'd2;
			pdfe_pkg::ST_FD_MUL2: begin
				mul_a = {16'd0, dd_q};
				mul_b = {8'd0, frac_q};
			end
			pdfe_pkg::ST_EMIT: out_load = out_free;
			default: ;
		endcase
	end

	// configuration port
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q <= 16'd0;
			pulse_max_q <= 16'd20000;
			mains_hz_q  <= 7'd50;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pdfe_pkg::CFG_PULSE_MIN: pulse_min_q <= cfg_data;
				pdfe_pkg::CFG_PULSE_MAX: pulse_max_q <= cfg_data;
				pdfe_pkg::CFG_MAINS_HZ:  mains_hz_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command capture and scratch registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q      <= s_tuser;
			chan_in_q <= s_tdata[0];
			dur_q     <= s_tdata[16:1];
			lvl_q     <= s_tdata[24:17];
			direct_q  <= s_tdata[40:25];
			idx_q     <= s_tdata[48:41];
			inc_q     <= s_tdata[64:49];
		end
		mul_q <= mul_a * mul_b;
		case (state_q)
			pdfe_pkg::ST_CH_CHECK: begin
				now_q <= now_c;
				up_q  <= chan_mode_q[ch_q] == pdfe_pkg::MODE_UP;
				lv_q  <= (chan_end_level_q[ch_q] > CS) ? CS : chan_end_level_q[ch_q];
			end
			pdfe_pkg::ST_FD_LV: begin
				lv_q   <= lv_c;
				frac_q <= div_quo[7:0];
				ph_q   <= 16'd0;
			end
			pdfe_pkg::ST_FD_GET1: ph_q <= ram_rdata;
			pdfe_pkg::ST_FD_GET2: dd_q <= up_q ? ph_q - ram_rdata : ram_rdata - ph_q;
			pdfe_pkg::ST_FD_CORR: ph_q <= up_q ? ph_q - corr_c : ph_q + corr_c;
			default: ;
		endcase
	end

	// channel state and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_sum_q <= 32'd0;
			cycle_q     <= 32'd0;
			ch_q        <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				chan_mode_q[i]        <= pdfe_pkg::MODE_OFF;
				chan_level_q[i]       <= 8'd0;
				chan_start_level_q[i] <= 8'd0;
				chan_end_level_q[i]   <= 8'd0;
				chan_level_span_q[i]  <= 8'd0;
				chan_start_cycle_q[i] <= 32'd0;
				chan_end_cycle_q[i]   <= 32'd0;
				chan_cycle_span_q[i]  <= 32'd0;
				chan_phase_q[i]       <= 16'd0;
				chan_enable_q[i]      <= 1'b0;
			end
		end else begin
			case (state_q)
				pdfe_pkg::ST_DECODE: begin
					ch_q <= (op_q == pdfe_pkg::OP_TICK) ? '0 : CHW'(chan_in_q);
					case (op_q)
						pdfe_pkg::OP_TICK: begin
							cycle_q <= cycle_q + 32'd1;
						end
						pdfe_pkg::OP_LOAD: begin
							curve_sum_q <= (idx_q == 8'd0) ? {16'd0, inc_q}
								: curve_sum_q + {16'd0, inc_q};
						end
						pdfe_pkg::OP_LEVEL: begin
							if (chan_ok) begin
								chan_level_span_q[CHW'(chan_in_q)] <= 8'd0;
								if (lvl_q == pdfe_pkg::LEVEL_OFF) begin
									chan_mode_q[CHW'(chan_in_q)]      <= pdfe_pkg::MODE_OFF;
									chan_level_q[CHW'(chan_in_q)]     <= 8'd0;
									chan_end_level_q[CHW'(chan_in_q)] <= 8'd0;
									chan_phase_q[CHW'(chan_in_q)]     <= 16'd0;
									chan_enable_q[CHW'(chan_in_q)]    <= 1'b0;
								end else if (lvl_q == pdfe_pkg::LEVEL_RECALL) begin
									if (chan_level_q[CHW'(chan_in_q)] != 8'd0) begin
										chan_end_level_q[CHW'(chan_in_q)] <=
											chan_level_q[CHW'(chan_in_q)];
										chan_mode_q[CHW'(chan_in_q)] <= pdfe_pkg::MODE_ON;
									end
								end
							end
						end
						pdfe_pkg::OP_DIRECT: begin
							if (chan_ok) begin
								chan_mode_q[CHW'(chan_in_q)]       <= pdfe_pkg::MODE_ON;
								chan_level_q[CHW'(chan_in_q)]      <= 8'd0;
								chan_end_level_q[CHW'(chan_in_q)]  <= 8'd0;
								chan_level_span_q[CHW'(chan_in_q)] <= 8'd0;
								chan_enable_q[CHW'(chan_in_q)]     <= 1'b1;
								chan_phase_q[CHW'(chan_in_q)]      <= direct_q;
							end
						end
						default: ;
					endcase
				end
				pdfe_pkg::ST_SF_SET: begin
					chan_start_cycle_q[ch_q] <= cycle_q;
					chan_cycle_span_q[ch_q]  <= div_quo[31:0];
					chan_end_cycle_q[ch_q]   <= cycle_q + div_quo[31:0];
					chan_start_level_q[ch_q] <= chan_level_q[ch_q];
					chan_end_level_q[ch_q]   <= lvl_q;
					if (chan_level_q[ch_q] < lvl_q) begin
						chan_mode_q[ch_q]       <= pdfe_pkg::MODE_UP;
						chan_level_span_q[ch_q] <= lvl_q - chan_level_q[ch_q];
						chan_enable_q[ch_q]     <= 1'b1;
					end else if (chan_level_q[ch_q] > lvl_q) begin
						chan_mode_q[ch_q]       <= pdfe_pkg::MODE_DOWN;
						chan_level_span_q[ch_q] <= chan_level_q[ch_q] - lvl_q;
						chan_enable_q[ch_q]     <= 1'b1;
					end
				end
				pdfe_pkg::ST_SL_GET: begin
					chan_mode_q[ch_q]      <= pdfe_pkg::MODE_ON;
					chan_enable_q[ch_q]    <= 1'b1;
					chan_level_q[ch_q]     <= lvl_sat;
					chan_end_level_q[ch_q] <= lvl_sat;
					chan_phase_q[ch_q]     <= ram_rdata;
				end
				pdfe_pkg::ST_ZS_GET: begin
					chan_level_q[ch_q] <= lv_q;
					chan_phase_q[ch_q] <= (lv_q == 8'd0) ? 16'd0 : ram_rdata;
					chan_mode_q[ch_q]  <= pdfe_pkg::MODE_DONE;
				end
				pdfe_pkg::ST_FD_LV: chan_level_q[ch_q] <= lv_c;
				pdfe_pkg::ST_FD_FIN: begin
					chan_phase_q[ch_q] <= ph_q;
					if (now_q == e_c) chan_mode_q[ch_q] <= pdfe_pkg::MODE_DONE;
				end
				pdfe_pkg::ST_EMIT: begin
					if (out_free && !is_last) ch_q <= ch_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {3'd0, chan_mode_q[ch_q], chan_enable_q[ch_q],
				chan_phase_q[ch_q], chan_level_q[ch_q], ch_q[0]};
			m_tlast_q <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	pdfe_ram #(
		.WIDTH(16),
		.DEPTH(256)
	) u_curve (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pdfe_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.dividend(div_num),
		.divisor (div_den),
		.rsp     (div_rsp),
		.quotient(div_quo)
	);

`ifndef SYNTHESIS
	// divider is only started when idle
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// no item is taken while a division runs
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_rsp.busy)
		else $error("item accepted during division");

	// a result is never loaded over a waiting one
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid || m_tready))
		else $error("result overwritten");

	// channel 0 level stays on the curve
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_level_q[0] <= CS)
		else $error("channel level off the curve");

	// a division result is followed by its consuming state
	a_done_used: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |=> (state_q == pdfe_pkg::ST_LT_WR || state_q == pdfe_pkg::ST_SF_SET
			|| state_q == pdfe_pkg::ST_FD_LV))
		else $error("division result dropped");
`endif

endmodule

// File: bench/phase_dimmer_fade_engine_unit_test.sv
`timescale 1ns / 100ps

module phase_dimmer_fade_engine_unit_test;

	localparam int NUM_CHAN = 2;
	localparam int TOP_LEVEL = 254;
	localparam int SCALE = 16384;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		logic        chan;
		logic [7:0]  bright;
		logic [15:0] phase;
		logic        enable;
		logic [2:0]  mode;
		logic        last;
	} chan_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [2:0]  s_tuser = pdfe_pkg::OP_TICK;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = pdfe_pkg::CFG_PULSE_MIN;
	logic [15:0] cfg_data = '0;

	phase_dimmer_fade_engine_unit dut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the block state
	logic [15:0] pulse_lo = 16'd0;
	logic [15:0] pulse_hi = 16'd20000;
	logic [6:0]  mains_hz = 7'd50;
	logic [15:0] curve [256];
	logic [31:0] curve_sum = '0;
	logic [31:0] cycle_cnt = '0;
	logic [2:0]  ch_mode [NUM_CHAN];
	logic [7:0]  ch_level [NUM_CHAN];
	logic [7:0]  ch_start_lvl [NUM_CHAN];
	logic [7:0]  ch_end_lvl [NUM_CHAN];
	logic [7:0]  ch_lvl_span [NUM_CHAN];
	logic [31:0] ch_start_cyc [NUM_CHAN];
	logic [31:0] ch_end_cyc [NUM_CHAN];
	logic [31:0] ch_cyc_span [NUM_CHAN];
	logic [15:0] ch_phase [NUM_CHAN];
	logic        ch_enable [NUM_CHAN];

	chan_result_t pending_states [$];
	int mismatches = 0;
	int burst_left = 0;

	initial begin
		for (int i = 0; i < 256; i++) curve[i] = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			ch_mode[c] = pdfe_pkg::MODE_OFF;
			ch_level[c] = '0;
			ch_start_lvl[c] = '0;
			ch_end_lvl[c] = '0;
			ch_lvl_span[c] = '0;
			ch_start_cyc[c] = '0;
			ch_end_cyc[c] = '0;
			ch_cyc_span[c] = '0;
			ch_phase[c] = '0;
			ch_enable[c] = 1'b0;
		end
	end

	function automatic logic [15:0] curve_entry(int unsigned lvl);
		return curve[(lvl - 1) & 8'hFF];
	endfunction

	// one fade update of a channel at the current cycle count
	function automatic void advance_fade(int c);
		logic [31:0] now, s, e, span, phase, dd, corr, whole, frac;
		longint unsigned prod;
		bit up;
		int lv;
		now = cycle_cnt;
		s = ch_start_cyc[c];
		e = ch_end_cyc[c];
		span = ch_cyc_span[c];
		up = (ch_mode[c] == pdfe_pkg::MODE_UP);
		if (span == 0) begin
			lv = (ch_end_lvl[c] > TOP_LEVEL) ? TOP_LEVEL : ch_end_lvl[c];
			ch_level[c] = lv[7:0];
			ch_phase[c] = (lv != 0) ? curve_entry(lv) : 16'd0;
			ch_mode[c] = pdfe_pkg::MODE_DONE;
			return;
		end
		// outside the fade window counts as the end cycle
		if (s < e) begin
			if (now < s || now > e) now = e;
		end else begin
			if (now < s && now > e) now = e;
		end
		prod = longint'(now - s) * ch_lvl_span[c];
		whole = (prod / span) & 32'hFF;
		frac = ((prod * 256) / span) & 32'hFF;
		lv = up ? int'(ch_start_lvl[c]) + int'(whole) : int'(ch_start_lvl[c]) - int'(whole);
		if (lv < 0) lv = 0;
		else if (lv > TOP_LEVEL) lv = TOP_LEVEL;
		ch_level[c] = lv[7:0];
		// interpolate toward the neighboring curve entry
		if (lv == 0) begin
			phase = 0;
		end else begin
			phase = curve_entry(lv);
			if (up && lv != TOP_LEVEL) begin
				dd = (phase - curve_entry(lv + 1)) & 32'hFFFF;
				corr = ((dd * frac + pdfe_pkg::ROUND_HALF) / 256) & 32'hFFFF;
				phase = (phase - corr) & 32'hFFFF;
			end else if (!up && lv != 1) begin
				dd = (curve_entry(lv - 1) - phase) & 32'hFFFF;
				corr = ((dd * frac + pdfe_pkg::ROUND_HALF) / 256) & 32'hFFFF;
				phase = (phase + corr) & 32'hFFFF;
			end
		end
		ch_phase[c] = phase[15:0];
		if (now == e) ch_mode[c] = pdfe_pkg::MODE_DONE;
	endfunction

	function automatic void push_state(int c, bit last);
		chan_result_t r;
		r.chan = c[0];
		r.bright = ch_level[c];
		r.phase = ch_phase[c];
		r.enable = ch_enable[c];
		r.mode = ch_mode[c];
		r.last = last;
		pending_states.push_back(r);
	endfunction

	// expected channel states caused by one command
	function automatic void predict_command(logic [2:0] op, logic ch, logic [15:0] dur,
			logic [7:0] lvl, logic [15:0] direct, logic [7:0] idx, logic [15:0] inc);
		logic [15:0] d;
		longint unsigned v;
		int c;
		c = ch;
		case (op)
			pdfe_pkg::OP_TICK: begin
				cycle_cnt = cycle_cnt + 1;
				for (int i = 0; i < NUM_CHAN; i++) begin
					if (ch_mode[i] == pdfe_pkg::MODE_UP || ch_mode[i] == pdfe_pkg::MODE_DOWN)
						advance_fade(i);
					push_state(i, i == NUM_CHAN - 1);
				end
			end
			pdfe_pkg::OP_LOAD: begin
				d = pulse_hi - pulse_lo;
				curve_sum = (idx == 0) ? 32'(inc) : curve_sum + inc;
				v = (longint'(d) * curve_sum + SCALE / 2) / SCALE;
				curve[idx] = pulse_hi - v[15:0];
			end
			pdfe_pkg::OP_FADE: begin
				ch_start_cyc[c] = cycle_cnt;
				ch_cyc_span[c] = (32'd2 * mains_hz * dur) / pdfe_pkg::MS_PER_SEC;
				ch_end_cyc[c] = cycle_cnt + ch_cyc_span[c];
				ch_start_lvl[c] = ch_level[c];
				ch_end_lvl[c] = lvl;
				if (ch_level[c] < lvl) begin
					ch_mode[c] = pdfe_pkg::MODE_UP;
					ch_lvl_span[c] = lvl - ch_level[c];
					ch_enable[c] = 1'b1;
				end else if (ch_level[c] > lvl) begin
					ch_mode[c] = pdfe_pkg::MODE_DOWN;
					ch_lvl_span[c] = ch_level[c] - lvl;
					ch_enable[c] = 1'b1;
				end
				push_state(c, 1'b1);
			end
			pdfe_pkg::OP_LEVEL: begin
				ch_lvl_span[c] = '0;
				if (lvl == pdfe_pkg::LEVEL_OFF) begin
					ch_mode[c] = pdfe_pkg::MODE_OFF;
					ch_level[c] = '0;
					ch_end_lvl[c] = '0;
					ch_phase[c] = '0;
					ch_enable[c] = 1'b0;
				end else if (lvl == pdfe_pkg::LEVEL_RECALL) begin
					if (ch_level[c] != 0) begin
						ch_end_lvl[c] = ch_level[c];
						ch_mode[c] = pdfe_pkg::MODE_ON;
					end
				end else begin
					if (lvl > TOP_LEVEL) lvl = TOP_LEVEL;
					ch_mode[c] = pdfe_pkg::MODE_ON;
					ch_enable[c] = 1'b1;
					ch_level[c] = lvl;
					ch_end_lvl[c] = lvl;
					ch_phase[c] = curve_entry(lvl);
				end
				push_state(c, 1'b1);
			end
			pdfe_pkg::OP_DIRECT: begin
				ch_mode[c] = pdfe_pkg::MODE_ON;
				ch_level[c] = '0;
				ch_end_lvl[c] = '0;
				ch_lvl_span[c] = '0;
				ch_enable[c] = 1'b1;
				ch_phase[c] = direct;
				push_state(c, 1'b1);
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] %s", $realtime, msg);
		mismatches++;
	endtask

	// send one command item, in bursts with random gaps
	task automatic send_command(logic [2:0] op, logic ch = 0, logic [15:0] dur = 0,
			logic [7:0] lvl = 0, logic [15:0] direct = 0, logic [7:0] idx = 0,
			logic [15:0] inc = 0);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = int'($urandom_range(1, 20));
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, inc, idx, direct, lvl, dur, ch};
		do @(posedge clk); while (!s_tready);
		predict_command(op, ch, dur, lvl, direct, idx, inc);
	endtask

	task automatic write_reg(logic [1:0] index, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			pdfe_pkg::CFG_PULSE_MIN: pulse_lo = value;
			pdfe_pkg::CFG_PULSE_MAX: pulse_hi = value;
			pdfe_pkg::CFG_MAINS_HZ:  mains_hz = value[6:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// let the block finish, including work that returns nothing
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_states.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [15:0] lo, logic [15:0] hi, logic [6:0] hz);
		settle();
		write_reg(pdfe_pkg::CFG_PULSE_MIN, lo);
		write_reg(pdfe_pkg::CFG_PULSE_MAX, hi);
		write_reg(pdfe_pkg::CFG_MAINS_HZ, {9'd0, hz});
	endtask

	// build the whole curve so no unwritten entry is ever read
	task automatic test_table_load();
		for (int i = 0; i < 256; i++)
			send_command(pdfe_pkg::OP_LOAD, .idx(8'(i)),
				.inc(i == 255 ? 16'hFFFF : 16'($urandom_range(0, 400))));
	endtask

	task automatic test_directed();
		send_command(pdfe_pkg::OP_LEVEL, 0, .lvl(pdfe_pkg::LEVEL_RECALL));  // recall, nothing stored
		send_command(pdfe_pkg::OP_LEVEL, 1, .lvl(8'd1));
		send_command(pdfe_pkg::OP_LEVEL, 0, .lvl(8'd254));
		send_command(pdfe_pkg::OP_LEVEL, 0, .lvl(pdfe_pkg::LEVEL_RECALL));
		send_command(pdfe_pkg::OP_LEVEL, 1, .lvl(pdfe_pkg::LEVEL_OFF));
		send_command(pdfe_pkg::OP_DIRECT, 0, .direct(16'hFFFF));
		send_command(pdfe_pkg::OP_DIRECT, 1, .direct(16'h0000));
		send_command(pdfe_pkg::OP_LEVEL, 0, .lvl(8'd100));
		send_command(pdfe_pkg::OP_FADE, 0, .dur(16'd0), .lvl(8'd255));   // zero span, saturates
		send_command(pdfe_pkg::OP_TICK);
		send_command(pdfe_pkg::OP_FADE, 0, .dur(16'd100), .lvl(8'd254)); // equal levels
		send_command(pdfe_pkg::OP_TICK);
		send_command(pdfe_pkg::OP_FADE, 1, .dur(16'd100), .lvl(8'd255));
		send_command(pdfe_pkg::OP_FADE, 0, .dur(16'd70), .lvl(8'd0));
		repeat (16) send_command(pdfe_pkg::OP_TICK);
		send_command(pdfe_pkg::OP_FADE, 1, .dur(16'hFFFF), .lvl(8'd3));
		send_command(3'd5, 1, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		send_command(3'd7);
		send_command(pdfe_pkg::OP_TICK);
	endtask

	// mostly fades driven by runs of ticks, with noise mixed in
	task automatic test_random(int count);
		int pick;
		logic [15:0] dur;
		for (int n = 0; n < count; n++) begin
			pick = int'($urandom_range(0, 99));
			dur = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
			if (pick < 50) send_command(pdfe_pkg::OP_TICK);
			else if (pick < 66)
				send_command(pdfe_pkg::OP_FADE, 1'($urandom), .dur(dur), .lvl(8'($urandom)));
			else if (pick < 78)
				send_command(pdfe_pkg::OP_LEVEL, 1'($urandom), .lvl(8'($urandom)));
			else if (pick < 84)
				send_command(pdfe_pkg::OP_DIRECT, 1'($urandom), .direct(16'($urandom)));
			else if (pick < 94)
				send_command(pdfe_pkg::OP_LOAD, .idx(8'($urandom)), .inc(16'($urandom)));
			else send_command(3'($urandom_range(5, 7)), 1'($urandom), 16'($urandom),
				8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
		end
	endtask

	// receiver stall pattern
	int unsigned stall_cnt = 0;
	int stall_kind = 0;
	logic [15:0] stall_bits = 16'hFFFF;
	always @(posedge clk) begin
		stall_cnt++;
		if (stall_cnt % 64 == 0) begin
			stall_kind = int'($urandom_range(0, 2));
			stall_bits = 16'($urandom);
		end
		case (stall_kind)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= stall_bits[stall_cnt[3:0]];
		endcase
	end

	// compare each result item with the oldest expected state; watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		chan_result_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[0], m_tdata[8:1], m_tdata[24:9], m_tdata[25], m_tdata[28:26],
				m_tlast};
			if (pending_states.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", got));
			end else begin
				want = pending_states.pop_front();
				if (got.chan !== want.chan)
					report_mismatch($sformatf("channel %b want %b", got.chan, want.chan));
				if (got.bright !== want.bright)
					report_mismatch($sformatf("ch%0d brightness %0d want %0d", want.chan,
						got.bright, want.bright));
				if (got.phase !== want.phase)
					report_mismatch($sformatf("ch%0d phase %0d want %0d", want.chan,
						got.phase, want.phase));
				if (got.enable !== want.enable)
					report_mismatch($sformatf("ch%0d enable %b want %b", want.chan,
						got.enable, want.enable));
				if (got.mode !== want.mode)
					report_mismatch($sformatf("ch%0d mode %0d want %0d", want.chan,
						got.mode, want.mode));
				if (got.last !== want.last)
					report_mismatch($sformatf("ch%0d last %b want %b", want.chan,
						got.last, want.last));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_states.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_config(16'd0, 16'd20000, 7'd50);
		test_table_load();
		test_directed();
		test_random(100);
		set_config(16'd0, 16'd65535, 7'd40);
		test_random(100);
		set_config(16'd65535, 16'd0, 7'd70);
		test_table_load();
		test_random(100);
		set_config(16'd1000, 16'd9000, 7'd60);
		test_random(100);
		settle();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
